// ===== rtl/bqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants for the saturating PCM16 biquad.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned DLY_W  = 40;
  localparam int unsigned ACC_W  = 46;
  localparam int unsigned PCM_W  = 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_B0 = 3'd0;
  localparam logic [2:0] REG_B1 = 3'd1;
  localparam logic [2:0] REG_B2 = 3'd2;
  localparam logic [2:0] REG_A1 = 3'd3;
  localparam logic [2:0] REG_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] B0_RST = 32'sh1000_0000;

  localparam logic signed [DLY_W-1:0] DLY_MAX = {1'b0, {(DLY_W-1){1'b1}}};
  localparam logic signed [DLY_W-1:0] DLY_MIN = {1'b1, {(DLY_W-1){1'b0}}};

  // +/- 2^31: halved output of magnitude one
  localparam logic signed [ACC_W-1:0] CLIP_POS = 46'sh0_8000_0000;
  localparam logic signed [ACC_W-1:0] CLIP_NEG = -46'sh0_8000_0000;

  typedef enum logic [2:0] {
    CSEL_B0,
    CSEL_B1,
    CSEL_B2,
    CSEL_A1,
    CSEL_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    VSEL_W1,
    VSEL_W2,
    VSEL_D
  } val_sel_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coefs_t;

  typedef struct packed {
    logic      load_x;
    logic      mul_en;
    coef_sel_t coef;
    val_sel_t  val;
    logic      hi;
    logic      sub;
    logic      sat_d;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== rtl/bqd_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_regs
// APB coefficient register file, five signed Q3.28 taps.
// ----------------------------------------------------------------------------
module bqd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bqd_pkg::ADDR_W-1:0] paddr,
  input  logic [bqd_pkg::DATA_W-1:0] pwdata,
  output logic [bqd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bqd_pkg::coefs_t            coefs
);
  import bqd_pkg::*;

  coefs_t     coefs_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign coefs  = coefs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.b0 <= B0_RST;
      coefs_r.b1 <= '0;
      coefs_r.b2 <= '0;
      coefs_r.a1 <= '0;
      coefs_r.a2 <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_B0:  coefs_r.b0 <= pwdata;
        REG_B1:  coefs_r.b1 <= pwdata;
        REG_B2:  coefs_r.b2 <= pwdata;
        REG_A1:  coefs_r.a1 <= pwdata;
        REG_A2:  coefs_r.a2 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_B0:  prdata = coefs_r.b0;
      REG_B1:  prdata = coefs_r.b1;
      REG_B2:  prdata = coefs_r.b2;
      REG_A1:  prdata = coefs_r.a1;
      REG_A2:  prdata = coefs_r.a2;
      default: prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bqd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_dp
// Biquad datapath: shared 32x21 multiplier, accumulator, delay line, output.
// ----------------------------------------------------------------------------
module bqd_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bqd_pkg::dp_cmd_t                 cmd,
  output bqd_pkg::dp_sts_t                 sts,
  input  bqd_pkg::coefs_t                  coefs,
  input  logic signed [bqd_pkg::PCM_W-1:0] in_sample_in,
  input  logic                             in_block_end_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bqd_pkg::PCM_W-1:0] out_sample_out,
  output logic                             out_clipped,
  output logic                             out_block_end_out
);
  import bqd_pkg::*;

  // operand select and product
  logic signed [COEF_W-1:0] mul_a;
  logic signed [DLY_W-1:0]  mul_v;
  logic signed [20:0]       mul_b;
  logic signed [52:0]       prod_nxt;
  logic signed [52:0]       prod_r;
  logic                     tag_vld_r;
  logic                     tag_hi_r;
  logic                     tag_sub_r;

  // reduction
  logic signed [32:0]       lo_r;
  logic signed [52:0]       psum;
  logic signed [44:0]       term;
  logic signed [ACC_W-1:0]  term_x;
  logic signed [ACC_W-1:0]  acc_r;

  // delay line
  logic signed [DLY_W-1:0]  w1_r;
  logic signed [DLY_W-1:0]  w2_r;
  logic signed [DLY_W-1:0]  d_r;
  logic signed [DLY_W-1:0]  d_nxt;
  logic                     blk_r;

  // output conversion
  logic                     clip_pos;
  logic                     clip_neg;
  logic                     neg;
  logic [ACC_W-1:0]         abs_y;
  logic [31:0]              mag;
  logic [46:0]              scaled;
  logic [PCM_W-1:0]         q;
  logic signed [PCM_W-1:0]  smp_nxt;

  logic                     out_valid_r;
  logic signed [PCM_W-1:0]  smp_r;
  logic                     clip_r;
  logic                     blk_out_r;

  always_comb begin
    unique case (cmd.coef)
      CSEL_B0: mul_a = coefs.b0;
      CSEL_B1: mul_a = coefs.b1;
      CSEL_B2: mul_a = coefs.b2;
      CSEL_A1: mul_a = coefs.a1;
      CSEL_A2: mul_a = coefs.a2;
      default: mul_a = '0;
    endcase
    unique case (cmd.val)
      VSEL_W1: mul_v = w1_r;
      VSEL_W2: mul_v = w2_r;
      VSEL_D:  mul_v = d_r;
      default: mul_v = '0;
    endcase
    // high half is floor(w / 2^20), low half the unsigned remainder
    mul_b    = cmd.hi ? {mul_v[DLY_W-1], mul_v[DLY_W-1:20]} : {1'b0, mul_v[19:0]};
    prod_nxt = mul_a * mul_b;
  end

  assign psum   = prod_r + {{20{lo_r[32]}}, lo_r};
  assign term   = psum[52:8];
  assign term_x = {{(ACC_W-45){term[44]}}, term};

  always_comb begin
    priority if (acc_r > $signed({{(ACC_W-DLY_W){1'b0}}, DLY_MAX})) begin
      d_nxt = DLY_MAX;
    end else if (acc_r < $signed({{(ACC_W-DLY_W){1'b1}}, DLY_MIN})) begin
      d_nxt = DLY_MIN;
    end else begin
      d_nxt = acc_r[DLY_W-1:0];
    end
  end

  always_comb begin
    clip_pos = acc_r > CLIP_POS;
    clip_neg = acc_r < CLIP_NEG;
    neg      = acc_r[ACC_W-1];
    abs_y    = neg ? (~acc_r + 1'b1) : acc_r;
    mag      = (clip_pos | clip_neg) ? 32'h8000_0000 : abs_y[31:0];
    scaled   = {mag, 15'b0} - {15'b0, mag};
    q        = scaled[46:31];
    smp_nxt  = neg ? -$signed(q) : $signed(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      w1_r        <= '0;
      w2_r        <= '0;
    end else begin
      tag_vld_r <= cmd.mul_en;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        w2_r        <= w1_r;
        w1_r        <= d_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    tag_hi_r  <= cmd.hi;
    tag_sub_r <= cmd.sub;
    if (tag_vld_r && !tag_hi_r) begin
      lo_r <= prod_r[52:20];
    end
    if (cmd.load_x) begin
      acc_r <= {{(ACC_W-31){in_sample_in[PCM_W-1]}}, in_sample_in, 15'b0};
      blk_r <= in_block_end_in;
    end else if (cmd.sat_d) begin
      acc_r <= '0;
      d_r   <= d_nxt;
    end else if (tag_vld_r && tag_hi_r) begin
      acc_r <= tag_sub_r ? acc_r - term_x : acc_r + term_x;
    end
    if (cmd.finish) begin
      smp_r     <= smp_nxt;
      clip_r    <= clip_pos | clip_neg;
      blk_out_r <= blk_r;
    end
  end

  assign sts.out_busy    = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = smp_r;
  assign out_clipped     = clip_r;
  assign out_block_end_out = blk_out_r;

endmodule

// ===== rtl/bqd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer: issues the ten half-products, the delay saturate step and the output step per word.
// ----------------------------------------------------------------------------
module bqd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output bqd_pkg::dp_cmd_t cmd,
  input  bqd_pkg::dp_sts_t sts
);
  import bqd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A1L, ST_A1H, ST_A2L, ST_A2H, ST_POST_D, ST_SAT,
    ST_B0L, ST_B0H, ST_B1L, ST_B1H, ST_B2L, ST_B2H, ST_POST_Y,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.coef   = CSEL_B0;
    cmd.val    = VSEL_W1;
    cmd.load_x = in_valid & in_ready;
    state_nxt  = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_A1L;
      ST_A1L: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_A1; cmd.val = VSEL_W1;
        state_nxt  = ST_A1H;
      end
      ST_A1H: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_A1; cmd.val = VSEL_W1;
        cmd.hi = 1'b1; cmd.sub = 1'b1;
        state_nxt  = ST_A2L;
      end
      ST_A2L: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_A2; cmd.val = VSEL_W2;
        state_nxt  = ST_A2H;
      end
      ST_A2H: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_A2; cmd.val = VSEL_W2;
        cmd.hi = 1'b1; cmd.sub = 1'b1;
        state_nxt  = ST_POST_D;
      end
      ST_POST_D: state_nxt = ST_SAT;
      ST_SAT: begin
        cmd.sat_d = 1'b1;
        state_nxt = ST_B0L;
      end
      ST_B0L: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B0; cmd.val = VSEL_D;
        state_nxt  = ST_B0H;
      end
      ST_B0H: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B0; cmd.val = VSEL_D; cmd.hi = 1'b1;
        state_nxt  = ST_B1L;
      end
      ST_B1L: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B1; cmd.val = VSEL_W1;
        state_nxt  = ST_B1H;
      end
      ST_B1H: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B1; cmd.val = VSEL_W1; cmd.hi = 1'b1;
        state_nxt  = ST_B2L;
      end
      ST_B2L: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B2; cmd.val = VSEL_W2;
        state_nxt  = ST_B2H;
      end
      ST_B2H: begin
        cmd.mul_en = 1'b1; cmd.coef = CSEL_B2; cmd.val = VSEL_W2; cmd.hi = 1'b1;
        state_nxt  = ST_POST_Y;
      end
      ST_POST_Y: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/biquad_iir_pcm16_saturating.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_pcm16_saturating
// Direct-form-II biquad on Q1.15 PCM with 40-bit saturating delay line.
// A new word is accepted only in the idle state, after the last word has
// run its ten half-products through one shared 32x21 multiplier plus the
// saturate and output steps; the output step waits on a busy output.
// Reset: coefficients to b0=1.0 and others 0, delay line cleared, no output.
// ----------------------------------------------------------------------------
module biquad_iir_pcm16_saturating (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bqd_pkg::ADDR_W-1:0]       paddr,
  input  logic [bqd_pkg::DATA_W-1:0]       pwdata,
  output logic [bqd_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [bqd_pkg::PCM_W-1:0] in_sample_in,
  input  logic                             in_block_end_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [bqd_pkg::PCM_W-1:0] out_sample_out,
  output logic                             out_clipped,
  output logic                             out_block_end_out
);
  import bqd_pkg::*;

  coefs_t  coefs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  bqd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  bqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bqd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .coefs             (coefs),
    .in_sample_in      (in_sample_in),
    .in_block_end_in   (in_block_end_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_clipped       (out_clipped),
    .out_block_end_out (out_block_end_out)
  );

endmodule

// ===== verif/biquad_iir_pcm16_saturating_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_pcm16_saturating_test
// Self-checking bench for the saturating PCM16 biquad. A bit-true filter
// predictor tracks the coefficients written over APB and the 40-bit delay
// line. Each accepted sample yields one expected word, and each word the
// block returns is compared with it. A directed set covers the clamp
// boundary, delay saturation, floor rounding and the coefficient extremes.
// After that come random buffers under several coefficient styles and
// idle patterns.
// ----------------------------------------------------------------------------
module biquad_iir_pcm16_saturating_test;
  import bqd_pkg::*;

  localparam int     CYCLE_LIMIT    = 400_000;
  localparam int     RAND_PHASES    = 10;
  localparam int     PHASE_ITEMS    = 65;
  localparam int     RX_HOLD_CYCLES = 400;
  localparam int     DRAIN_CYCLES   = 40;
  localparam longint Q15_TO_Q30     = 32768;
  localparam longint PCM_FULL_SCALE = 32767;

  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  typedef enum int {
    STYLE_GENTLE,
    STYLE_WIDE,
    STYLE_FULL,
    STYLE_CORNER
  } coef_style_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] sample;
    logic                    block_end;
  } pcm_item_t;

  typedef struct {
    logic signed [PCM_W-1:0] sample;
    logic                    clipped;
    logic                    block_end;
  } pcm_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [PCM_W-1:0] in_sample_in = '0;
  logic                    in_block_end_in = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [PCM_W-1:0] out_sample_out;
  logic                    out_clipped;
  logic                    out_block_end_out;

  biquad_iir_pcm16_saturating dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_in      (in_sample_in),
    .in_block_end_in   (in_block_end_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sample_out    (out_sample_out),
    .out_clipped       (out_clipped),
    .out_block_end_out (out_block_end_out)
  );

  // filter state mirrored by the predictor
  logic signed [COEF_W-1:0] coef_model [0:4];
  logic signed [DLY_W-1:0]  w1_model = '0;
  logic signed [DLY_W-1:0]  w2_model = '0;
  string coef_names [0:4] = '{"coef_b0", "coef_b1", "coef_b2", "coef_a1", "coef_a2"};

  pcm_item_t pcm_backlog [$];
  pcm_word_t filtered_expect [$];
  pcm_word_t due_word;

  logic in_taken = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   rx_hold_req = 0;
  int   rx_hold_served = 0;
  int   rx_hold_left = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   words_checked = 0;
  int   clipped_seen = 0;
  int   ends_seen = 0;
  int   sat_hits = 0;
  int   settings_used = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // floor(c * v / 2^28)
  function automatic longint q28_product(logic signed [COEF_W-1:0] c, longint v);
    logic signed [127:0] p;
    p = c * v;
    return longint'(p >>> 28);
  endfunction

  function automatic pcm_word_t filter_step(pcm_item_t item);
    longint    x, d, acc, h, mag, q;
    pcm_word_t r;
    x = longint'(item.sample) * Q15_TO_Q30;
    d = x - q28_product(coef_model[REG_A1], w1_model)
          - q28_product(coef_model[REG_A2], w2_model);
    if (d > DLY_MAX) begin
      d = DLY_MAX;
      sat_hits++;
    end else if (d < DLY_MIN) begin
      d = DLY_MIN;
      sat_hits++;
    end
    acc = q28_product(coef_model[REG_B0], d)
        + q28_product(coef_model[REG_B1], w1_model)
        + q28_product(coef_model[REG_B2], w2_model);
    w2_model = w1_model;
    w1_model = d[DLY_W-1:0];
    // acc in Q15.30 read as Q.31 is the halved output
    h = acc;
    r.clipped = 1'b0;
    if (acc > CLIP_POS) begin
      h = CLIP_POS;
      r.clipped = 1'b1;
    end else if (acc < CLIP_NEG) begin
      h = CLIP_NEG;
      r.clipped = 1'b1;
    end
    mag = (h < 0) ? -h : h;
    q = (mag * PCM_FULL_SCALE) >>> 31;
    r.sample = PCM_W'((h < 0) ? -q : q);
    r.block_end = item.block_end;
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(coef_style_t style);
    case (style)
      STYLE_GENTLE: return $urandom_range(32'h2000_0000) - 32'h1000_0000;
      STYLE_WIDE:   return $urandom_range(32'h8000_0000) - 32'h4000_0000;
      STYLE_FULL:   return $urandom;
      default: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic logic [PCM_W-1:0] pick_sample();
    int r;
    r = $urandom_range(9);
    if (r < 5) begin
      return PCM_W'($urandom);
    end else if (r < 8) begin
      return PCM_W'($urandom_range(1024) - 512);
    end
    case ($urandom_range(3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx <= REG_A2) coef_model[idx] = data;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic read_check(input logic [2:0] idx);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== coef_model[idx]) begin
      $error("%s: expected %h, got %h", coef_names[idx], coef_model[idx], prdata);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_coef(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    write_reg(idx, data);
    read_check(idx);
  endtask

  task automatic offer(input logic [PCM_W-1:0] sample, input logic last);
    pcm_backlog.push_back('{sample: sample, block_end: last});
  endtask

  // sender holds back until every expected word has come
  task automatic settle();
    while (pcm_backlog.size() != 0 || in_valid || filtered_expect.size() != 0)
      @(posedge clk);
  endtask

  // input side driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pcm_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_sample_in <= pcm_backlog[0].sample;
        in_block_end_in <= pcm_backlog[0].block_end;
        pcm_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side ready, with a long hold on request
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_hold_req != rx_hold_served) begin
      rx_hold_served <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        filtered_expect.push_back(filter_step('{sample: in_sample_in,
                                               block_end: in_block_end_in}));
      if (out_valid && out_ready) begin
        if (filtered_expect.size() == 0) begin
          $error("word with no sample pending: sample_out %0d", out_sample_out);
          mismatches++;
        end else begin
          due_word = filtered_expect.pop_front();
          words_checked++;
          if (due_word.clipped) clipped_seen++;
          if (due_word.block_end) ends_seen++;
          if (out_sample_out !== due_word.sample) begin
            $error("sample_out: expected %0d, got %0d", due_word.sample, out_sample_out);
            mismatches++;
          end
          if (out_clipped !== due_word.clipped) begin
            $error("clipped: expected %0b, got %0b", due_word.clipped, out_clipped);
            mismatches++;
          end
          if (out_block_end_out !== due_word.block_end) begin
            $error("block_end_out: expected %0b, got %0b", due_word.block_end,
                   out_block_end_out);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          len;
    int          left;
    coef_style_t style;

    coef_model[REG_B0] = B0_RST;
    coef_model[REG_B1] = '0;
    coef_model[REG_B2] = '0;
    coef_model[REG_A1] = '0;
    coef_model[REG_A2] = '0;
    tx_idle_pct = 8;
    rx_idle_pct = 73;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = REG_B0; i <= REG_A2; i++) read_check(3'(i));

    // reset coefficients: pass-through, output at half the input
    offer(16'h7FFF, 1'b0);
    offer(16'h8000, 1'b1);
    offer(16'h0000, 1'b0);
    offer(16'h0001, 1'b0);
    offer(16'hFFFF, 1'b1);
    offer(16'h4000, 1'b0);
    offer(16'hBFFF, 1'b1);
    settle();
    settings_used++;

    // clamp boundary: halved output of exactly one is not clipped
    set_coef(REG_B0, 32'h2000_0000);
    offer(16'h8000, 1'b0);
    offer(16'h7FFF, 1'b1);
    settle();
    set_coef(REG_B0, 32'h4000_0000);
    offer(16'h4000, 1'b0);
    offer(16'h4001, 1'b0);
    offer(16'hC000, 1'b0);
    offer(16'hBFFF, 1'b1);
    settle();

    // tiny negative gain: products floor toward minus infinity
    set_coef(REG_B0, 32'hFFFF_FFFF);
    offer(16'h0001, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h7FFF, 1'b1);
    settle();

    // coefficient extremes, runaway feedback into delay saturation
    write_reg(REG_SPARE_FIRST, 32'hDEAD_BEEF);
    set_coef(REG_B0, 32'h7FFF_FFFF);
    set_coef(REG_B1, 32'h8000_0000);
    set_coef(REG_B2, 32'h7FFF_FFFF);
    set_coef(REG_A1, 32'h8000_0000);
    set_coef(REG_A2, 32'h7FFF_FFFF);
    write_reg(REG_SPARE_LAST, 32'h1234_5678);
    read_check(REG_B0);
    offer(16'h7FFF, 1'b0);
    offer(16'h8000, 1'b0);
    offer(16'h7FFF, 1'b0);
    offer(16'h7FFF, 1'b0);
    offer(16'h8000, 1'b0);
    offer(16'h0000, 1'b0);
    offer(16'h0000, 1'b0);
    offer(16'h0000, 1'b1);
    settle();
    settings_used += 4;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 8;
        rx_idle_pct = 73;
      end else if (ph < 7) begin
        tx_idle_pct = 73;
        rx_idle_pct = 8;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      style = coef_style_t'(ph % 4);
      for (int i = REG_B0; i <= REG_A2; i++) set_coef(3'(i), pick_coef(style));
      if ($urandom_range(2) == 0)
        write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom);
      settings_used++;
      if (ph == 2 || ph == 8) rx_hold_req++;
      left = PHASE_ITEMS;
      while (left > 0) begin
        len = $urandom_range(24, 1);
        if (len > left) len = left;
        for (int k = 0; k < len; k++) offer(pick_sample(), k == len - 1);
        left -= len;
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d filtered words over %0d coefficient settings.",
             words_checked, settings_used);
    $display("%0d clipped, %0d buffer ends, %0d delay saturations predicted.",
             clipped_seen, ends_seen, sat_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bqd_pkg.sv
rtl/bqd_regs.sv
rtl/bqd_dp.sv
rtl/bqd_ctrl.sv
rtl/biquad_iir_pcm16_saturating.sv
verif/biquad_iir_pcm16_saturating_test.sv
